FILE: rtl/core/kvt_pkg.sv
// Shared types, command and status codes for the key/value table.
package kvt_pkg;

    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 64;
    localparam int ACT_BITS   = 3;
    localparam int STAT_BITS  = 4;
    localparam int S_TDATA_W  = 104;
    localparam int M_TDATA_W  = 104;
    localparam int CAPACITY_DEF   = 64;
    localparam int VALUE_BITS_DEF = 64;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_PUT    = 3'd0,
        ACT_GET    = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_DUMP   = 3'd4
    } t_action;

    typedef enum logic [STAT_BITS-1:0] {
        ST_INSERTED  = 4'd0,
        ST_UPDATED   = 4'd1,
        ST_FOUND     = 4'd2,
        ST_NOT_FOUND = 4'd3,
        ST_DELETED   = 4'd4,
        ST_CLEARED   = 4'd5,
        ST_ENTRY     = 4'd6,
        ST_FULL      = 4'd7,
        ST_EMPTY     = 4'd8
    } t_status;

    // Commands broadcast from the controller to every cell of the row.
    typedef struct packed {
        logic look;    // register the key compare
        logic upd;     // matching cell takes the new value
        logic ins;     // cell at the fill point takes key and value
        logic del;     // cells at or above the hit index take their neighbor
        logic rot;     // row rotates by one toward cell 0
    } t_cell_ctl;

endpackage

FILE: rtl/core/kvt_cell.sv
// One table cell: holds a key and value, compares, and shifts toward its lower neighbor.
module kvt_cell #(
    parameter int INDEX      = 0,
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  kvt_pkg::t_cell_ctl                    i_ctl,
    input  logic signed [kvt_pkg::KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0]                 i_value,
    input  logic [$clog2(CAPACITY+1)-1:0]         i_count,
    input  logic [$clog2(CAPACITY)-1:0]           i_idx,
    input  logic signed [kvt_pkg::KEY_BITS-1:0]   i_next_key,
    input  logic [VALUE_BITS-1:0]                 i_next_value,
    input  logic signed [kvt_pkg::KEY_BITS-1:0]   i_head_key,
    input  logic [VALUE_BITS-1:0]                 i_head_value,
    output logic signed [kvt_pkg::KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0]                 o_value,
    output logic                                  o_match
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] POS_C = CW'(INDEX);
    localparam logic [IW-1:0] POS_I = IW'(INDEX);

    logic signed [kvt_pkg::KEY_BITS-1:0] r_key;
    logic [VALUE_BITS-1:0]               r_value;
    logic                                r_match;
    logic                                w_in_use;
    logic                                w_tail;

    assign w_in_use = POS_C < i_count;
    assign w_tail   = POS_C == (i_count - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else if (i_ctl.look) begin
            r_match <= w_in_use && (r_key == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rot) begin
            // The tail wraps around to the head so the row returns to order.
            if (w_tail) begin
                r_key   <= i_head_key;
                r_value <= i_head_value;
            end else begin
                r_key   <= i_next_key;
                r_value <= i_next_value;
            end
        end else if (i_ctl.del && (POS_I >= i_idx)) begin
            r_key   <= i_next_key;
            r_value <= i_next_value;
        end else if (i_ctl.ins && (POS_C == i_count)) begin
            r_key   <= i_key;
            r_value <= i_value;
        end else if (i_ctl.upd && r_match) begin
            r_value <= i_value;
        end
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_match = r_match;

endmodule

FILE: rtl/core/key_value_table.sv
// Ordered key/value table: a row of storage cells under a small command controller.
//
// Slave channel (i_s_*) takes one command per request: action, key and value.
// Master channel (o_m_*) returns result requests: status, key and value, with
// o_m_tlast set on the final result of each command.
// Put, get, delete and clear produce one result. A command is registered on
// acceptance, the key compare across all cells is registered in the next cycle,
// and the table update and result load follow once the result register is free,
// when a new command may be accepted again. Dump rotates the cell row once per
// result; an empty table gives one empty result.
// The result register frees the slave side while a result waits; if the
// receiver holds i_m_tready low, the controller waits with its next result and
// stops accepting commands once it has one ready to load.
// Synchronous active-low reset empties the table and drops any pending result.
module key_value_table #(
    parameter int CAPACITY   = kvt_pkg::CAPACITY_DEF,
    parameter int VALUE_BITS = kvt_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [2:0] action, [34:3] key, [98:35] value, [103:99] zero
    input  logic [kvt_pkg::S_TDATA_W-1:0] i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [3:0] status, [35:4] out_key, [99:36] out_value, [103:100] zero
    output logic [kvt_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tlast
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KB = kvt_pkg::KEY_BITS;
    localparam int DB = kvt_pkg::DATA_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_EXEC = 4'b0100,
        S_DUMP = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [IW-1:0] r_dcnt, n_dcnt;

    logic [kvt_pkg::ACT_BITS-1:0] r_act;
    logic signed [KB-1:0]         r_key;
    logic [VALUE_BITS-1:0]        r_value;

    logic                     r_out_valid;
    kvt_pkg::t_status         r_out_status, n_out_status;
    logic signed [KB-1:0]     r_out_key, n_out_key;
    logic [DB-1:0]            r_out_value, n_out_value;
    logic                     r_out_last, n_out_last;
    logic                     w_out_load;

    kvt_pkg::t_cell_ctl   w_ctl;
    logic signed [KB-1:0]  w_key   [CAPACITY];
    logic [VALUE_BITS-1:0] w_value [CAPACITY];
    logic [CAPACITY-1:0]   w_match;

    logic                  w_hit;
    logic [IW-1:0]         w_hit_idx;
    logic signed [KB-1:0]  w_rd_key;
    logic [VALUE_BITS-1:0] w_rd_value;
    logic                  w_out_free;
    logic                  w_in_fire;
    logic                  w_dump_busy;

    // Cell row; each cell's neighbor is the next one up, the top one sees the head.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [KB-1:0]  w_nkey;
        logic [VALUE_BITS-1:0] w_nval;
        if (g == CAPACITY - 1) begin : g_top
            assign w_nkey = w_key[0];
            assign w_nval = w_value[0];
        end else begin : g_mid
            assign w_nkey = w_key[g+1];
            assign w_nval = w_value[g+1];
        end
        kvt_cell #(
            .INDEX      (g),
            .CAPACITY   (CAPACITY),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_key),
            .i_value      (r_value),
            .i_count      (r_count),
            .i_idx        (w_hit_idx),
            .i_next_key   (w_nkey),
            .i_next_value (w_nval),
            .i_head_key   (w_key[0]),
            .i_head_value (w_value[0]),
            .o_key        (w_key[g]),
            .o_value      (w_value[g]),
            .o_match      (w_match[g])
        );
    end

    // Keys are unique, so at most one cell matches: plain AND-OR selection.
    always_comb begin
        w_hit_idx  = '0;
        w_rd_key   = '0;
        w_rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (w_match[i]) begin
                w_hit_idx  = w_hit_idx | IW'(i);
                w_rd_key   = w_rd_key | w_key[i];
                w_rd_value = w_rd_value | w_value[i];
            end
        end
    end
    assign w_hit = |w_match;

    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_dump_busy = (r_act == kvt_pkg::ACT_DUMP) && (r_count != '0);
    assign o_s_tready  = (r_state == S_IDLE) ||
                         ((r_state == S_EXEC) && w_out_free && !w_dump_busy);
    assign w_in_fire   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_dcnt       = r_dcnt;
        w_ctl        = '0;
        w_out_load   = 1'b0;
        n_out_status = kvt_pkg::ST_EMPTY;
        n_out_key    = '0;
        n_out_value  = '0;
        n_out_last   = 1'b1;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                w_ctl.look = 1'b1;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = w_in_fire ? S_LOOK : S_IDLE;
                    case (r_act)
                        kvt_pkg::ACT_PUT: begin
                            w_out_load = 1'b1;
                            if (w_hit) begin
                                w_ctl.upd    = 1'b1;
                                n_out_status = kvt_pkg::ST_UPDATED;
                            end else if (r_count < CAP_C) begin
                                w_ctl.ins    = 1'b1;
                                n_count      = r_count + CW'(1);
                                n_out_status = kvt_pkg::ST_INSERTED;
                            end else begin
                                n_out_status = kvt_pkg::ST_FULL;
                            end
                        end
                        kvt_pkg::ACT_GET: begin
                            w_out_load = 1'b1;
                            if (w_hit) begin
                                n_out_status = kvt_pkg::ST_FOUND;
                                n_out_key    = w_rd_key;
                                n_out_value  = DB'(w_rd_value);
                            end else begin
                                n_out_status = kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kvt_pkg::ACT_DELETE: begin
                            w_out_load = 1'b1;
                            if (w_hit) begin
                                w_ctl.del    = 1'b1;
                                n_count      = r_count - CW'(1);
                                n_out_status = kvt_pkg::ST_DELETED;
                            end else begin
                                n_out_status = kvt_pkg::ST_NOT_FOUND;
                            end
                        end
                        kvt_pkg::ACT_CLEAR: begin
                            w_out_load   = 1'b1;
                            n_count      = '0;
                            n_out_status = kvt_pkg::ST_CLEARED;
                        end
                        kvt_pkg::ACT_DUMP: begin
                            if (r_count == '0) begin
                                w_out_load   = 1'b1;
                                n_out_status = kvt_pkg::ST_EMPTY;
                            end else begin
                                n_state = S_DUMP;
                                n_dcnt  = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    // Cell 0 always holds the next entry; rotating restores order.
                    w_ctl.rot    = 1'b1;
                    w_out_load   = 1'b1;
                    n_out_status = kvt_pkg::ST_ENTRY;
                    n_out_key    = w_key[0];
                    n_out_value  = DB'(w_value[0]);
                    n_out_last   = (CW'(r_dcnt) == (r_count - CW'(1)));
                    n_dcnt       = r_dcnt + IW'(1);
                    if (n_out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_dcnt      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_dcnt  <= n_dcnt;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_act   <= i_s_tdata[2:0];
            r_key   <= i_s_tdata[34:3];
            r_value <= i_s_tdata[35 +: VALUE_BITS];
        end
        if (w_out_load) begin
            r_out_status <= n_out_status;
            r_out_key    <= n_out_key;
            r_out_value  <= n_out_value;
            r_out_last   <= n_out_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {4'b0, r_out_value, r_out_key, r_out_status};

    // The table never grows past its capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_C)
        else $error("entry count above capacity");

    // Keys stay unique, so the registered compare hits at most one cell.
    a_single_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("more than one cell matched the key");

    // A dump sequence only runs over a non-empty table.
    a_dump_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DUMP) |-> (r_count != '0))
        else $error("dump running on an empty table");

    // A clear result leaves the table empty.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (n_out_status == kvt_pkg::ST_CLEARED)) |=> (r_count == '0))
        else $error("clear did not empty the table");

endmodule

FILE: tb/sv/key_value_table_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the key/value table against a behavioral table.
module key_value_table_tb;

    localparam int ACT_W         = kvt_pkg::ACT_BITS;
    localparam int KEY_W         = kvt_pkg::KEY_BITS;
    localparam int DATA_W        = kvt_pkg::DATA_BITS;
    localparam int STAT_W        = kvt_pkg::STAT_BITS;
    localparam int S_W           = kvt_pkg::S_TDATA_W;
    localparam int M_W           = kvt_pkg::M_TDATA_W;
    localparam int CAP           = kvt_pkg::CAPACITY_DEF;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 100;
    localparam int RANDOM_ITEMS  = 128;
    localparam int MAX_ERR_SHOWN = 10;
    localparam int POOL_SIZE     = 8;
    localparam int PAD_BITS      = S_W - ACT_W - KEY_W - DATA_W;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [ACT_W-1:0]        action;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       value;
        int                      phase;
        bit                      drain_first;
    } t_kv_cmd;

    typedef struct {
        kvt_pkg::t_status        status;
        logic signed [KEY_W-1:0] key;
        logic [DATA_W-1:0]       value;
        logic                    last;
    } t_kv_result;

    logic           i_clk      = 1'b0;
    logic           i_rst_n    = 1'b0;
    logic           i_s_tvalid = 1'b0;
    logic           o_s_tready;
    // [2:0] action, [34:3] key, [98:35] value, [103:99] zero
    logic [S_W-1:0] i_s_tdata  = '0;
    logic           o_m_tvalid;
    logic           i_m_tready = 1'b0;
    // [3:0] status, [35:4] out_key, [99:36] out_value, [103:100] zero
    logic [M_W-1:0] o_m_tdata;
    logic           o_m_tlast;

    key_value_table uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Behavioral copy of the table.
    logic signed [KEY_W-1:0] table_keys [CAP];
    logic [DATA_W-1:0]       table_values [CAP];
    int                      table_count = 0;

    t_kv_cmd    pending_cmds [$];
    t_kv_result expected_results [$];
    t_kv_cmd    offered_cmd;
    t_kv_result got_result;
    t_kv_result want_result;
    bit         take_next;

    logic signed [KEY_W-1:0] fill_keys [$];
    int gen_phase    = 0;
    bit drain_next   = 1'b0;
    int n_generated  = 0;
    int n_accepted   = 0;
    int n_errors     = 0;
    int active_phase = 0;
    int hold_at      = 1 << 30;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int stall_cycles = 0;

    function automatic int sender_idle_pct(int ph);
        case (ph)
            0:       return 14;
            1:       return 48;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct(int ph);
        case (ph)
            0:       return 48;
            1:       return 14;
            default: return 0;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_value();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ACT_W-1:0] unused_action();
        return ACT_W'($urandom_range(7, kvt_pkg::ACT_DUMP + 1));
    endfunction

    function automatic int find_entry(logic signed [KEY_W-1:0] key);
        for (int i = 0; i < table_count; i++) begin
            if (table_keys[i] == key) return i;
        end
        return table_count;
    endfunction

    function automatic void push_result(kvt_pkg::t_status st,
                                        logic signed [KEY_W-1:0] key,
                                        logic [DATA_W-1:0] value, logic last);
        t_kv_result r;
        r.status = st;
        r.key    = key;
        r.value  = value;
        r.last   = last;
        expected_results.push_back(r);
    endfunction

    // Updates the table for one accepted command and queues the results it causes.
    function automatic void apply_command(t_kv_cmd c);
        int idx;
        idx = find_entry(c.key);
        case (c.action)
            kvt_pkg::ACT_PUT: begin
                if (idx < table_count) begin
                    table_values[idx] = c.value;
                    push_result(kvt_pkg::ST_UPDATED, '0, '0, 1'b1);
                end else if (table_count < CAP) begin
                    table_keys[table_count]   = c.key;
                    table_values[table_count] = c.value;
                    table_count++;
                    push_result(kvt_pkg::ST_INSERTED, '0, '0, 1'b1);
                end else begin
                    push_result(kvt_pkg::ST_FULL, '0, '0, 1'b1);
                end
            end
            kvt_pkg::ACT_GET: begin
                if (idx < table_count)
                    push_result(kvt_pkg::ST_FOUND, table_keys[idx], table_values[idx], 1'b1);
                else
                    push_result(kvt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
            end
            kvt_pkg::ACT_DELETE: begin
                if (idx < table_count) begin
                    for (int j = idx; j + 1 < table_count; j++) begin
                        table_keys[j]   = table_keys[j+1];
                        table_values[j] = table_values[j+1];
                    end
                    table_count--;
                    push_result(kvt_pkg::ST_DELETED, '0, '0, 1'b1);
                end else begin
                    push_result(kvt_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
                end
            end
            kvt_pkg::ACT_CLEAR: begin
                table_count = 0;
                push_result(kvt_pkg::ST_CLEARED, '0, '0, 1'b1);
            end
            kvt_pkg::ACT_DUMP: begin
                if (table_count == 0) begin
                    push_result(kvt_pkg::ST_EMPTY, '0, '0, 1'b1);
                end else begin
                    for (int j = 0; j < table_count; j++)
                        push_result(kvt_pkg::ST_ENTRY, table_keys[j], table_values[j],
                                    j == table_count - 1);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void add_cmd(logic [ACT_W-1:0] action,
                                    logic signed [KEY_W-1:0] key,
                                    logic [DATA_W-1:0] value);
        t_kv_cmd c;
        c.action      = action;
        c.key         = key;
        c.value       = value;
        c.phase       = gen_phase;
        c.drain_first = drain_next;
        drain_next    = 1'b0;
        pending_cmds.push_back(c);
        if (action <= kvt_pkg::ACT_DUMP) n_generated++;
    endfunction

    function automatic logic signed [KEY_W-1:0] fresh_fill_key();
        logic signed [KEY_W-1:0] k;
        bit clash;
        do begin
            k = $urandom;
            clash = 1'b0;
            foreach (fill_keys[i]) if (fill_keys[i] == k) clash = 1'b1;
        end while (clash);
        fill_keys.push_back(k);
        return k;
    endfunction

    // Driver: a command waiting with drain_first is held back until every result is in.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            take_next = !i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                apply_command(offered_cmd);
                n_accepted <= n_accepted + 1;
                take_next = 1'b1;
            end
            if (take_next) begin
                if (pending_cmds.size() != 0
                        && !(pending_cmds[0].drain_first && expected_results.size() != 0)
                        && $urandom_range(99) >= sender_idle_pct(pending_cmds[0].phase)) begin
                    offered_cmd = pending_cmds.pop_front();
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {{PAD_BITS{1'b0}}, offered_cmd.value, offered_cmd.key,
                                   offered_cmd.action};
                    active_phase <= offered_cmd.phase;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off while the table is being filled.
    always @(posedge i_clk) begin
        if (!hold_done && n_accepted >= hold_at) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor and result checker.
    always @(posedge i_clk) begin
        i_m_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct(active_phase));
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_result.status = kvt_pkg::t_status'(o_m_tdata[STAT_W-1:0]);
            got_result.key    = o_m_tdata[STAT_W +: KEY_W];
            got_result.value  = o_m_tdata[STAT_W+KEY_W +: DATA_W];
            got_result.last   = o_m_tlast;
            if (expected_results.size() == 0) begin
                if (n_errors < MAX_ERR_SHOWN)
                    $display("unexpected result: status %0d key %0d value %h last %b",
                             got_result.status, got_result.key, got_result.value,
                             got_result.last);
                n_errors++;
            end else begin
                want_result = expected_results.pop_front();
                if (got_result.status !== want_result.status
                        || got_result.key !== want_result.key
                        || got_result.value !== want_result.value
                        || got_result.last !== want_result.last) begin
                    if (n_errors < MAX_ERR_SHOWN) begin
                        $display("result mismatch: expected status %0d key %0d value %h last %b",
                                 want_result.status, want_result.key, want_result.value,
                                 want_result.last);
                        $display("                 got status %0d key %0d value %h last %b",
                                 got_result.status, got_result.key, got_result.value,
                                 got_result.last);
                    end
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which neither side moves a request.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("key_value_table_tb: FAIL");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
        logic signed [KEY_W-1:0] key;
        int  session_len;
        int  pick;
        bit  fill_done;

        fill_done = 1'b0;

        // Directed part: empty table, key extremes, update, deletes at both ends
        // and in the middle, unused actions and ignored fields.
        add_cmd(kvt_pkg::ACT_DUMP, '0, '0);
        add_cmd(kvt_pkg::ACT_GET, '0, '0);
        add_cmd(kvt_pkg::ACT_DELETE, '0, '1);
        add_cmd(kvt_pkg::ACT_PUT, KEY_MIN, '0);
        add_cmd(kvt_pkg::ACT_PUT, KEY_MAX, '1);
        add_cmd(kvt_pkg::ACT_PUT, '0, 64'haaaa_aaaa_aaaa_aaaa);
        add_cmd(kvt_pkg::ACT_PUT, -32'sd1, 64'h5555_5555_5555_5555);
        add_cmd(kvt_pkg::ACT_PUT, KEY_MAX, 64'h0123_4567_89ab_cdef);
        add_cmd(kvt_pkg::ACT_GET, KEY_MIN, '1);
        add_cmd(kvt_pkg::ACT_GET, KEY_MAX, rand_value());
        add_cmd(kvt_pkg::ACT_GET, 32'sd12345, '0);
        add_cmd(kvt_pkg::ACT_DELETE, '0, rand_value());
        add_cmd(kvt_pkg::ACT_DUMP, '1, '1);
        add_cmd(ACT_W'(kvt_pkg::ACT_DUMP + 1), $urandom, rand_value());
        add_cmd(ACT_W'(kvt_pkg::ACT_DUMP + 2), $urandom, rand_value());
        add_cmd('1, '1, '1);
        add_cmd(kvt_pkg::ACT_DELETE, KEY_MIN, '0);
        add_cmd(kvt_pkg::ACT_DELETE, -32'sd1, '0);
        add_cmd(kvt_pkg::ACT_DUMP, '0, '0);
        add_cmd(kvt_pkg::ACT_CLEAR, '1, '1);
        add_cmd(kvt_pkg::ACT_DUMP, '0, '0);
        add_cmd(kvt_pkg::ACT_GET, KEY_MAX, '0);

        n_generated = 0;
        while (n_generated < RANDOM_ITEMS) begin
            if (n_generated >= 2 * RANDOM_ITEMS / 3) begin
                gen_phase = 2;
            end else if (n_generated >= RANDOM_ITEMS / 3) begin
                if (gen_phase == 0) drain_next = 1'b1;
                gen_phase = 1;
            end

            if (gen_phase == 2 && !fill_done) begin
                // Fill the table to capacity, then exercise full, update, get, a large dump and delete.
                fill_done  = 1'b1;
                drain_next = 1'b1;
                fill_keys.delete();
                add_cmd(kvt_pkg::ACT_CLEAR, $urandom, rand_value());
                for (int i = 0; i < CAP; i++) begin
                    add_cmd(kvt_pkg::ACT_PUT, fresh_fill_key(), rand_value());
                    if (i == 10) hold_at = pending_cmds.size();
                end
                add_cmd(kvt_pkg::ACT_PUT, fresh_fill_key(), rand_value());
                add_cmd(kvt_pkg::ACT_PUT, fill_keys[5], rand_value());
                add_cmd(kvt_pkg::ACT_GET, fill_keys[CAP-1], rand_value());
                add_cmd(kvt_pkg::ACT_DUMP, $urandom, rand_value());
                add_cmd(kvt_pkg::ACT_DELETE, fill_keys[30], rand_value());
                add_cmd(kvt_pkg::ACT_PUT, fresh_fill_key(), rand_value());
                add_cmd(kvt_pkg::ACT_PUT, fresh_fill_key(), rand_value());
                add_cmd(kvt_pkg::ACT_DUMP, $urandom, rand_value());
            end else if ($urandom_range(9) == 0) begin
                // Noise: unused actions and an occasional clear.
                add_cmd(unused_action(), $urandom, rand_value());
                if ($urandom_range(2) == 0)
                    add_cmd(kvt_pkg::ACT_CLEAR, $urandom, rand_value());
            end else begin
                // A session of commands on a small set of keys so that hits are common.
                for (int i = 0; i < POOL_SIZE; i++) begin
                    pick = $urandom_range(99);
                    if (pick < 10)      key_pool[i] = KEY_MIN;
                    else if (pick < 20) key_pool[i] = KEY_MAX;
                    else if (pick < 45) key_pool[i] = $urandom_range(15);
                    else                key_pool[i] = $urandom;
                end
                session_len = $urandom_range(12, 4);
                repeat (session_len) begin
                    pick = $urandom_range(99);
                    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(POOL_SIZE-1)];
                    else                         key = $urandom;
                    if (pick < 40)      add_cmd(kvt_pkg::ACT_PUT, key, rand_value());
                    else if (pick < 65) add_cmd(kvt_pkg::ACT_GET, key, rand_value());
                    else if (pick < 85) add_cmd(kvt_pkg::ACT_DELETE, key, rand_value());
                    else if (pick < 93) add_cmd(kvt_pkg::ACT_DUMP, key, rand_value());
                    else if (pick < 96) add_cmd(kvt_pkg::ACT_CLEAR, key, rand_value());
                    else                add_cmd(unused_action(), key, rand_value());
                end
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || i_s_tvalid) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("key_value_table_tb: PASS");
        end else begin
            $display("key_value_table_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/kvt_pkg.sv
rtl/core/kvt_cell.sv
rtl/core/key_value_table.sv
tb/sv/key_value_table_tb.sv
